@@ src/sfd_pkg.sv @@
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int unsigned HdrLen   = 12;
  localparam int unsigned BlkLen   = 8;
  localparam int unsigned LenW     = 4;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned RowsW    = 15;
  localparam int unsigned BlocksW  = 14;

  localparam logic REG_CGA_MODE = 1'b0;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BLOCK,
    PH_PASS
  } phase_e;

  typedef struct packed {
    logic [HdrLen-1:0][7:0] bytes;
    logic [LenW-1:0]        len;
    logic                   done;
  } grp_t;

endpackage

@@ src/sfd_ingest.sv @@
`timescale 1ns / 1ps

module sfd_ingest (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cga_mode_i,
  input  logic          in_valid_i,
  input  logic [7:0]    data_byte_i,
  input  logic          frame_last_i,
  input  logic          can_load_i,
  output logic          in_stall_o,
  output logic          push_o,
  output sfd_pkg::grp_t grp_o
);

  logic [sfd_pkg::HdrLen-1:0][7:0] hdr_q;
  logic [sfd_pkg::BlkLen-1:0][7:0] blk_q;
  logic [sfd_pkg::LenW-1:0]        pos_q, pos_d;
  sfd_pkg::phase_e                 phase_q, phase_d;
  logic [sfd_pkg::RowsW-1:0]       rows_q, rows_d;
  logic [sfd_pkg::BlocksW-1:0]     bpr_q, bpr_d;
  logic [sfd_pkg::BlocksW-1:0]     bleft_q, bleft_d;

  logic [sfd_pkg::HdrLen-1:0][7:0] hcur, hx;
  logic [sfd_pkg::BlkLen-1:0][7:0] bcur, bq, bx;
  logic [15:0]                     v0, v2;
  logic [15:0]                     wq;
  logic                            swap_all, blk_go;
  logic                            hdr_full, blk_full, grp_evt, accept;
  logic [sfd_pkg::BlocksW-1:0]     bleft_dec;
  logic [sfd_pkg::RowsW-1:0]       rows_dec;

  always_comb begin
    for (int i = 0; i < sfd_pkg::HdrLen; i++) begin
      hcur[i] = (pos_q == i[sfd_pkg::LenW-1:0]) ? data_byte_i : hdr_q[i];
    end
    for (int i = 0; i < sfd_pkg::BlkLen; i++) begin
      bcur[i] = (pos_q[2:0] == i[2:0]) ? data_byte_i : blk_q[i];
    end
  end

  // header rewrite
  always_comb begin
    swap_all = !hcur[10][7] && ({hcur[10], hcur[11]} != 16'h0000);
    wq       = {hcur[8], hcur[9]};
    blk_go   = swap_all && (hcur[3][7:6] == 2'b00) && (wq[15:2] != '0);
    hx[10]   = hcur[11];
    hx[11]   = hcur[10];
    for (int k = 0; k < 5; k++) begin
      hx[2*k]   = swap_all ? hcur[2*k+1] : hcur[2*k];
      hx[2*k+1] = swap_all ? hcur[2*k]   : hcur[2*k+1];
    end
  end

  // block permute and CGA interleave
  always_comb begin
    bq[0] = bcur[0]; bq[1] = bcur[2]; bq[2] = bcur[4]; bq[3] = bcur[6];
    bq[4] = bcur[1]; bq[5] = bcur[3]; bq[6] = bcur[5]; bq[7] = bcur[7];
    for (int i = 0; i < 8; i++) begin
      v0[2*i+1] = bq[0][i];
      v0[2*i]   = bq[1][i];
      v2[2*i+1] = bq[4][i];
      v2[2*i]   = bq[5][i];
    end
    if (cga_mode_i) begin
      bx[0] = v0[7:0];  bx[1] = v0[15:8];
      bx[4] = v2[7:0];  bx[5] = v2[15:8];
      bx[2] = 8'h00; bx[3] = 8'h00; bx[6] = 8'h00; bx[7] = 8'h00;
    end else begin
      bx = bq;
    end
  end

  assign hdr_full  = (pos_q == sfd_pkg::LenW'(sfd_pkg::HdrLen - 1));
  assign blk_full  = (pos_q[2:0] == 3'(sfd_pkg::BlkLen - 1));
  assign bleft_dec = bleft_q - 1'b1;
  assign rows_dec  = rows_q - 1'b1;

  always_comb begin
    grp_o.bytes = '0;
    grp_o.len   = pos_q + 1'b1;
    grp_o.done  = frame_last_i;
    grp_evt     = 1'b1;
    case (phase_q)
      sfd_pkg::PH_HEADER: begin
        grp_evt     = hdr_full || frame_last_i;
        grp_o.bytes = hdr_full ? hx : hcur;
      end
      sfd_pkg::PH_BLOCK: begin
        grp_evt = blk_full || frame_last_i;
        grp_o.len = {1'b0, pos_q[2:0]} + 1'b1;
        for (int i = 0; i < sfd_pkg::BlkLen; i++) begin
          grp_o.bytes[i] = blk_full ? bx[i] : bcur[i];
        end
      end
      default: begin
        grp_o.bytes[0] = data_byte_i;
        grp_o.len      = sfd_pkg::LenW'(1);
      end
    endcase
  end

  assign in_stall_o = grp_evt && !can_load_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept && grp_evt;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    rows_d  = rows_q;
    bpr_d   = bpr_q;
    bleft_d = bleft_q;
    case (phase_q)
      sfd_pkg::PH_HEADER: begin
        pos_d = grp_evt ? '0 : pos_q + 1'b1;
        if (hdr_full) begin
          phase_d = sfd_pkg::PH_PASS;
          if (blk_go) begin
            phase_d = sfd_pkg::PH_BLOCK;
            bpr_d   = wq[15:2];
            bleft_d = wq[15:2];
            rows_d  = {hcur[10][6:0], hcur[11]};
          end
        end
      end
      sfd_pkg::PH_BLOCK: begin
        pos_d = grp_evt ? '0 : pos_q + 1'b1;
        if (blk_full) begin
          bleft_d = bleft_dec;
          if (bleft_dec == '0) begin
            rows_d = rows_dec;
            if (rows_dec == '0) begin
              phase_d = sfd_pkg::PH_PASS;
            end else begin
              bleft_d = bpr_q;
            end
          end
        end
      end
      default: begin
        pos_d = '0;
      end
    endcase
    if (frame_last_i) begin
      phase_d = sfd_pkg::PH_HEADER;
      pos_d   = '0;
      rows_d  = '0;
      bpr_d   = '0;
      bleft_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfd_pkg::PH_HEADER;
      pos_q   <= '0;
      rows_q  <= '0;
      bpr_q   <= '0;
      bleft_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      rows_q  <= rows_d;
      bpr_q   <= bpr_d;
      bleft_q <= bleft_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (phase_q == sfd_pkg::PH_HEADER)) begin
      hdr_q[pos_q] <= data_byte_i;
    end
    if (accept && (phase_q == sfd_pkg::PH_BLOCK)) begin
      blk_q[pos_q[2:0]] <= data_byte_i;
    end
  end

endmodule

@@ src/sfd_emit_buf.sv @@
`timescale 1ns / 1ps

module sfd_emit_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfd_pkg::grp_t grp_i,
  input  logic          out_stall_i,
  output logic          can_load_o,
  output logic          out_valid_o,
  output logic [7:0]    out_byte_o,
  output logic          run_last_o,
  output logic          frame_done_o
);

  logic [sfd_pkg::HdrLen-1:0][7:0] buf_q;
  logic [sfd_pkg::LenW-1:0]        cnt_q;
  logic                            done_q;
  logic                            out_acc, one_left;

  assign one_left     = (cnt_q == sfd_pkg::LenW'(1));
  assign out_valid_o  = (cnt_q != '0);
  assign out_acc      = out_valid_o && !out_stall_i;
  assign can_load_o   = (cnt_q == '0) || (one_left && out_acc);
  assign out_byte_o   = buf_q[0];
  assign run_last_o   = one_left;
  assign frame_done_o = one_left && done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (push_i) begin
      cnt_q  <= grp_i.len;
      done_q <= grp_i.done;
    end else if (out_acc) begin
      cnt_q  <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q <= grp_i.bytes;
    end else if (out_acc) begin
      for (int i = 0; i < sfd_pkg::HdrLen - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
      buf_q[sfd_pkg::HdrLen-1] <= 8'h00;
    end
  end

endmodule

@@ src/sprite_frame_deinterleave_top.sv @@
`timescale 1ns / 1ps
// The first byte of a group is offered in the cycle after the beat that completes it.
// Input takes one beat per cycle unless stalled; results drain at one beat per cycle
// while out_stall_i is low, so input stalls only while a completed group waits for the
// output buffer to empty (after a header, when pixel blocks, a pass byte or a short
// frame follow it; none in steady block or pass traffic with the output unstalled).
// Reset: asynchronous, active low; header phase, empty buffer, cga_mode cleared.
module sprite_frame_deinterleave_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfd_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       frame_last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       run_last_o,
  output logic                       frame_done_o
);

  logic          cga_q;
  logic          sel_cga;
  logic          can_load, push;
  sfd_pkg::grp_t grp;

  assign pready  = 1'b1;
  assign sel_cga = (paddr[2] == sfd_pkg::REG_CGA_MODE);
  assign prdata  = sel_cga ? {31'b0, cga_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cga_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && sel_cga) begin
      cga_q <= pwdata[0];
    end
  end

  sfd_ingest u_ingest (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cga_mode_i   (cga_q),
    .in_valid_i   (in_valid_i),
    .data_byte_i  (data_byte_i),
    .frame_last_i (frame_last_i),
    .can_load_i   (can_load),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .grp_o        (grp)
  );

  sfd_emit_buf u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .grp_i        (grp),
    .out_stall_i  (out_stall_i),
    .can_load_o   (can_load),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .frame_done_o (frame_done_o)
  );

  a_done_is_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> run_last_o)
    else $error("frame_done without run_last");

  a_stall_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output buffer");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_o)
    else $error("loaded group not offered");

endmodule
